FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the receiver datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define SWR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("swr assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define SWR_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("swr assertion failed");

`endif

FILE: hw/rtl/swr_pkg.sv
// Shared types and constants of the sliding window receiver.
package swr_pkg;

  localparam int WINDOW_MAX_DEF = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SEL_REPEAT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd1;

  localparam logic [2:0] K_CONN       = 3'd0;
  localparam logic [2:0] K_PUSH       = 3'd1;
  localparam logic [2:0] K_DATA       = 3'd2;
  localparam logic [2:0] K_STOP       = 3'd3;
  localparam logic [2:0] K_DISCONNECT = 3'd4;
  localparam logic [2:0] K_ACK        = 3'd5;

  localparam logic [1:0] RK_DELIVER  = 2'd0;
  localparam logic [1:0] RK_ACK      = 2'd1;
  localparam logic [1:0] RK_COMPLETE = 2'd2;
  localparam logic [1:0] RK_SESSION  = 2'd3;

  typedef enum logic [2:0] {
    E_DLV, E_ACK, E_ACK_LOW, E_CMP, E_SES
  } esel_t;

  typedef struct packed {
    logic  latch;
    logic  commit;
    logic  rd;
    logic  emit;
    esel_t esel;
    logic  flush;
  } cmd_t;

  typedef struct packed {
    logic kind_ignored;
    logic kind_conn;
    logic st_idle;
    logic below;
    logic above;
    logic sel_repeat;
    logic peer_known;
    logic head_valid;
    logic stop;
    logic gen_ok;
    logic out_free;
    logic pend_v;
  } stat_t;

endpackage

FILE: hw/rtl/swr_ctrl.sv
// Sequencer of the receiver: walks one packet through check, buffer, delivery, acks, completion and session results.
module swr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  swr_pkg::stat_t st,
  output swr_pkg::cmd_t  cmd
);
  import swr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_EARLY_ACK, S_EARLY_LOW, S_LOOP, S_DLV,
    S_ACK, S_CMP, S_SES, S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.esel  = E_DLV;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.kind_ignored) begin
          state_nxt = S_IDLE;
        end else if (!st.st_idle && st.below) begin
          state_nxt = S_EARLY_ACK;
        end else if (!st.st_idle && st.above) begin
          state_nxt = st.sel_repeat ? S_FLUSH : S_EARLY_LOW;
        end else if (st.st_idle && !st.kind_conn && (st.below || st.above)) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_LOOP;
        end
      end
      S_EARLY_ACK: begin
        if (!st.peer_known) begin
          state_nxt = S_FLUSH;
        end else if (st.gen_ok) begin
          cmd.emit  = 1'b1;
          cmd.esel  = E_ACK;
          state_nxt = S_FLUSH;
        end
      end
      S_EARLY_LOW: begin
        if (!st.peer_known) begin
          state_nxt = S_FLUSH;
        end else if (st.gen_ok) begin
          cmd.emit  = 1'b1;
          cmd.esel  = E_ACK_LOW;
          state_nxt = S_FLUSH;
        end
      end
      S_LOOP: begin
        if (st.head_valid) begin
          cmd.rd    = 1'b1;
          state_nxt = S_DLV;
        end else begin
          state_nxt = S_ACK;
        end
      end
      S_DLV: begin
        if (st.gen_ok) begin
          cmd.emit  = 1'b1;
          cmd.esel  = E_DLV;
          state_nxt = S_LOOP;
        end
      end
      S_ACK: begin
        if (!st.peer_known) begin
          state_nxt = S_CMP;
        end else if (st.gen_ok) begin
          cmd.emit  = 1'b1;
          cmd.esel  = E_ACK;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (!(st.stop && st.below)) begin
          state_nxt = S_SES;
        end else if (st.gen_ok) begin
          cmd.emit  = 1'b1;
          cmd.esel  = E_CMP;
          state_nxt = S_SES;
        end
      end
      S_SES: begin
        if (!(st.st_idle && st.below)) begin
          state_nxt = S_FLUSH;
        end else if (st.gen_ok) begin
          cmd.emit  = 1'b1;
          cmd.esel  = E_SES;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!st.pend_v) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/swr_dp.sv
// Datapath of the receiver: connection state, window, slot store and result registers.
`include "assert_macros.svh"
module swr_dp #(
  parameter int WINDOW_MAX = swr_pkg::WINDOW_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swr_pkg::cmd_t                  cmd,
  output swr_pkg::stat_t                 st,
  input  logic [2:0]                     in_kind,
  input  logic [31:0]                    in_seq,
  input  logic [15:0]                    in_source,
  input  logic [15:0]                    in_payload_tag,
  input  logic                           cfg_valid,
  input  logic [swr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_result_kind,
  output logic [31:0]                    out_result_seq,
  output logic [2:0]                     out_acked_kind,
  output logic [15:0]                    out_destination,
  output logic [15:0]                    out_delivered_tag,
  output logic                           out_last
);
  import swr_pkg::*;

  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [IW:0]  WMAX_I = (IW + 1)'(WINDOW_MAX);
  localparam logic [32:0]  WMAX_W = 33'(WINDOW_MAX);

  typedef enum logic [1:0] {C_IDLE, C_CONNECTED, C_RECEIVING} conn_t;

  typedef struct packed {
    logic [1:0]  rkind;
    logic [31:0] seq;
    logic [2:0]  akind;
    logic [15:0] dest;
    logic [15:0] tag;
  } res_t;

  // Configuration.
  logic                  sel_repeat_r;
  logic [CFG_DATA_W-1:0] win_size_r;

  // Connection state.
  conn_t                 conn_r, conn_nxt;
  logic [31:0]           wl_r, wl_nxt;
  logic [IW-1:0]         wl_idx_r, wl_idx_nxt;
  logic [WINDOW_MAX-1:0] valid_r, valid_nxt;
  logic                  peer_known_r, peer_known_nxt;
  logic [15:0]           peer_r, peer_nxt;
  logic                  stop_r, stop_nxt;

  // Current packet.
  logic [2:0]  kind_r;
  logic [31:0] seq_r;
  logic [15:0] src_r;
  logic [15:0] tag_r;

  // Slot store.
  logic [15:0] tag_mem [WINDOW_MAX];
  logic [15:0] rdata_r;

  // Result staging.
  res_t pend_r, out_r, res_new;
  logic pend_v_r;
  logic out_valid_r;
  logic out_last_r;

  logic [32:0]   eff_win, hi;
  logic [31:0]   diff;
  logic [IW:0]   sum, idx_full;
  logic [IW-1:0] slot_idx;
  logic          conn_req;
  logic          slot_was_valid;
  logic          out_free;
  logic [WINDOW_MAX-1:0] base_valid;

  always_comb begin
    if (win_size_r == '0) begin
      eff_win = 33'd1;
    end else if (33'(win_size_r) > WMAX_W) begin
      eff_win = WMAX_W;
    end else begin
      eff_win = 33'(win_size_r);
    end
    hi = {1'b0, wl_r} + eff_win;
  end

  assign conn_req = (conn_r == C_IDLE) && (kind_r == K_CONN);

  // Slots are addressed by offset from the low edge, so only valid slots ever matter and a
  // connection request can restart the low edge at slot zero.
  always_comb begin
    diff = seq_r - wl_r;
    sum  = {1'b0, wl_idx_r} + diff[IW:0];
    if (sum >= WMAX_I) begin
      idx_full = sum - WMAX_I;
    end else begin
      idx_full = sum;
    end
    slot_idx = conn_req ? '0 : idx_full[IW-1:0];
  end

  assign base_valid     = conn_req ? '0 : valid_r;
  assign slot_was_valid = base_valid[slot_idx];
  assign out_free       = !out_valid_r || out_ready;

  always_comb begin
    res_new = '0;
    case (cmd.esel)
      E_DLV: begin
        res_new.rkind = RK_DELIVER;
        res_new.seq   = wl_r;
        res_new.tag   = rdata_r;
      end
      E_ACK: begin
        res_new.rkind = RK_ACK;
        res_new.seq   = sel_repeat_r ? seq_r : wl_r;
        res_new.akind = kind_r;
        res_new.dest  = peer_r;
      end
      E_ACK_LOW: begin
        res_new.rkind = RK_ACK;
        res_new.seq   = wl_r;
        res_new.akind = kind_r;
        res_new.dest  = peer_r;
      end
      E_CMP: begin
        res_new.rkind = RK_COMPLETE;
        res_new.seq   = seq_r;
      end
      E_SES: begin
        res_new.rkind = RK_SESSION;
        res_new.seq   = seq_r;
      end
      default: res_new = '0;
    endcase
  end

  always_comb begin
    conn_nxt       = conn_r;
    wl_nxt         = wl_r;
    wl_idx_nxt     = wl_idx_r;
    valid_nxt      = valid_r;
    peer_known_nxt = peer_known_r;
    peer_nxt       = peer_r;
    stop_nxt       = stop_r;
    if (cmd.latch) begin
      stop_nxt = 1'b0;
    end
    if (cmd.commit) begin
      case (conn_r)
        C_IDLE: begin
          if (kind_r == K_CONN) begin
            peer_nxt       = src_r;
            peer_known_nxt = 1'b1;
            conn_nxt       = C_CONNECTED;
            wl_nxt         = seq_r;
            wl_idx_nxt     = '0;
          end
        end
        C_RECEIVING: begin
          if (kind_r == K_STOP) begin
            stop_nxt = 1'b1;
            conn_nxt = C_CONNECTED;
          end
        end
        C_CONNECTED: begin
          if (kind_r == K_PUSH) begin
            conn_nxt = C_RECEIVING;
          end else if (kind_r == K_DISCONNECT) begin
            conn_nxt = C_IDLE;
          end
        end
        default: conn_nxt = C_IDLE;
      endcase
      valid_nxt           = base_valid;
      valid_nxt[slot_idx] = 1'b1;
    end
    if (cmd.emit && cmd.esel == E_DLV) begin
      valid_nxt[wl_idx_r] = 1'b0;
      wl_nxt              = wl_r + 32'd1;
      if (32'(wl_idx_r) == WINDOW_MAX - 1) begin
        wl_idx_nxt = '0;
      end else begin
        wl_idx_nxt = wl_idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_repeat_r <= 1'b0;
      win_size_r   <= CFG_DATA_W'(8);
      conn_r       <= C_IDLE;
      wl_r         <= '0;
      wl_idx_r     <= '0;
      valid_r      <= '0;
      peer_known_r <= 1'b0;
      peer_r       <= '0;
      stop_r       <= 1'b0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SEL_REPEAT:  sel_repeat_r <= cfg_data[0];
          CFG_WINDOW_SIZE: win_size_r   <= cfg_data;
          default: ;
        endcase
      end
      conn_r       <= conn_nxt;
      wl_r         <= wl_nxt;
      wl_idx_r     <= wl_idx_nxt;
      valid_r      <= valid_nxt;
      peer_known_r <= peer_known_nxt;
      peer_r       <= peer_nxt;
      stop_r       <= stop_nxt;
      if (cmd.flush || (cmd.emit && pend_v_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit) begin
        pend_v_r <= 1'b1;
      end
      if (cmd.flush) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // Payload registers and memory.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      seq_r  <= in_seq;
      src_r  <= in_source;
      tag_r  <= in_payload_tag;
    end
    // The first tag kept in a slot wins.
    if (cmd.commit && !slot_was_valid) begin
      tag_mem[slot_idx] <= tag_r;
    end
    if (cmd.rd) begin
      rdata_r <= tag_mem[wl_idx_r];
    end
    if (cmd.emit) begin
      pend_r <= res_new;
      if (pend_v_r) begin
        out_r      <= pend_r;
        out_last_r <= 1'b0;
      end
    end
    if (cmd.flush) begin
      out_r      <= pend_r;
      out_last_r <= 1'b1;
    end
  end

  always_comb begin
    st              = '0;
    st.kind_ignored = (kind_r >= K_ACK);
    st.kind_conn    = (kind_r == K_CONN);
    st.st_idle      = (conn_r == C_IDLE);
    st.below        = (seq_r < wl_r);
    st.above        = ({1'b0, seq_r} >= hi);
    st.sel_repeat   = sel_repeat_r;
    st.peer_known   = peer_known_r;
    st.head_valid   = valid_r[wl_idx_r];
    st.stop         = stop_r;
    st.gen_ok       = !pend_v_r || out_free;
    st.out_free     = out_free;
    st.pend_v       = pend_v_r;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_r.rkind;
  assign out_result_seq    = out_r.seq;
  assign out_acked_kind    = out_r.akind;
  assign out_destination   = out_r.dest;
  assign out_delivered_tag = out_r.tag;
  assign out_last          = out_last_r;

  `SWR_ASSERT(a_emit_room, cmd.emit |-> (!pend_v_r || out_free))
  `SWR_ASSERT_NEXT(a_flush_last, cmd.flush, out_valid_r && out_last_r && !pend_v_r)
  `SWR_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r && $stable(out_r))

endmodule

FILE: hw/rtl/sliding_window_receiver_unit.sv
// Top level of the sliding window receiver: sequencer plus datapath.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | kind, seq, source, payload_tag
//  out     | output    | out_valid / out_ready | result_kind, result_seq, acked_kind,
//          |           |                       | destination, delivered_tag, last
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One packet is worked at a time. An ignored or dropped packet returns to idle after its
// check, an out-of-window packet may get an early ack, an in-window one delivers its words.
// Synchronous reset clears connection state, window and slot valid bits, and resets config.
// A stalled output holds the sequencer at its next result; cfg_ready is always high.
module sliding_window_receiver_unit #(
  parameter int WINDOW_MAX = swr_pkg::WINDOW_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_kind,
  input  logic [31:0]                    in_seq,
  input  logic [15:0]                    in_source,
  input  logic [15:0]                    in_payload_tag,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_result_kind,
  output logic [31:0]                    out_result_seq,
  output logic [2:0]                     out_acked_kind,
  output logic [15:0]                    out_destination,
  output logic [15:0]                    out_delivered_tag,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [swr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import swr_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  swr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  swr_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_kind           (in_kind),
    .in_seq            (in_seq),
    .in_source         (in_source),
    .in_payload_tag    (in_payload_tag),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_result_seq    (out_result_seq),
    .out_acked_kind    (out_acked_kind),
    .out_destination   (out_destination),
    .out_delivered_tag (out_delivered_tag),
    .out_last          (out_last)
  );

endmodule

FILE: test/sliding_window_receiver_unit_tb.sv
// Self-checking testbench for the sliding window receiver unit.
module sliding_window_receiver_unit_tb;
  import swr_pkg::*;

  localparam int WIN_MAX     = 32;
  localparam int RAND_ITEMS  = 72;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 150;

  typedef enum logic [1:0] {CS_IDLE, CS_CONNECTED, CS_RECEIVING} conn_t;

  typedef struct packed {
    logic [1:0]  rkind;
    logic [31:0] rseq;
    logic [2:0]  akind;
    logic [15:0] dest;
    logic [15:0] tag;
    logic        is_last;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_kind = '0;
  logic [31:0] in_seq = '0;
  logic [15:0] in_source = '0;
  logic [15:0] in_payload_tag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_result_kind;
  logic [31:0] out_result_seq;
  logic [2:0] out_acked_kind;
  logic [15:0] out_destination;
  logic [15:0] out_delivered_tag;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sliding_window_receiver_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver model state.
  logic        m_sel_repeat;
  logic [5:0]  m_win_size;
  conn_t       m_state;
  logic [31:0] m_low;
  logic        m_slot_valid [WIN_MAX];
  logic [15:0] m_slot_tag [WIN_MAX];
  logic        m_peer_known;
  logic [15:0] m_peer;

  word_t expected_words[$];
  word_t pkt_words[$];
  int    mismatches = 0;
  int    items_sent = 0;
  int    words_checked = 0;
  int    cycles = 0;
  bit    quiet = 0;
  int    stall_left = 0;

  function automatic int eff_window();
    int w;
    w = m_win_size;
    if (w < 1) w = 1;
    if (w > WIN_MAX) w = WIN_MAX;
    return w;
  endfunction

  function automatic void add_word(logic [1:0] rk, logic [31:0] sq, logic [2:0] ak,
                                   logic [15:0] dst, logic [15:0] tg);
    word_t w;
    w = '{rk, sq, ak, dst, tg, 1'b0};
    pkt_words.push_back(w);
  endfunction

  function automatic void add_ack(logic [31:0] sq, logic [2:0] kind);
    if (m_peer_known) add_word(RK_ACK, sq, kind, m_peer, 16'd0);
  endfunction

  function automatic void reset_receiver();
    m_sel_repeat = 1'b0;
    m_win_size = 6'd8;
    m_state = CS_IDLE;
    m_low = '0;
    m_peer_known = 1'b0;
    m_peer = '0;
    for (int i = 0; i < WIN_MAX; i++) begin
      m_slot_valid[i] = 1'b0;
      m_slot_tag[i] = '0;
    end
  endfunction

  // Works out the words one packet produces and updates the receiver state.
  function automatic void predict_packet(logic [2:0] kind, logic [31:0] seq,
                                         logic [15:0] src, logic [15:0] tag);
    logic [32:0] hi;
    logic [4:0]  idx;
    logic [4:0]  k;
    bit          stop_seen;
    bit          out_of_window;
    stop_seen = 0;
    out_of_window = 0;
    pkt_words.delete();
    if (kind >= K_ACK) return;
    hi = {1'b0, m_low} + 33'(eff_window());
    if (m_state != CS_IDLE) begin
      if (seq < m_low) begin
        add_ack(m_sel_repeat ? seq : m_low, kind);
        out_of_window = 1;
      end else if ({1'b0, seq} >= hi) begin
        if (!m_sel_repeat) add_ack(m_low, kind);
        out_of_window = 1;
      end
    end else if (kind != K_CONN && (seq < m_low || {1'b0, seq} >= hi)) begin
      return;
    end
    if (!out_of_window) begin
      case (m_state)
        CS_IDLE: begin
          if (kind == K_CONN) begin
            m_peer = src;
            m_peer_known = 1'b1;
            m_state = CS_CONNECTED;
            m_low = seq;
            for (int i = 0; i < WIN_MAX; i++) m_slot_valid[i] = 1'b0;
          end
        end
        CS_RECEIVING: begin
          if (kind == K_STOP) begin
            stop_seen = 1;
            m_state = CS_CONNECTED;
          end
        end
        default: begin
          if (kind == K_PUSH) m_state = CS_RECEIVING;
          else if (kind == K_DISCONNECT) m_state = CS_IDLE;
        end
      endcase
      idx = seq[4:0];
      if (!m_slot_valid[idx]) begin
        m_slot_valid[idx] = 1'b1;
        m_slot_tag[idx] = tag;
      end
      for (int i = 0; i < WIN_MAX; i++) begin
        k = m_low[4:0];
        if (!m_slot_valid[k]) break;
        add_word(RK_DELIVER, m_low, 3'd0, 16'd0, m_slot_tag[k]);
        m_slot_valid[k] = 1'b0;
        m_low = m_low + 32'd1;
      end
      add_ack(m_sel_repeat ? seq : m_low, kind);
      if (stop_seen && seq < m_low) add_word(RK_COMPLETE, seq, 3'd0, 16'd0, 16'd0);
      if (m_state == CS_IDLE && seq < m_low) add_word(RK_SESSION, seq, 3'd0, 16'd0, 16'd0);
    end
    if (pkt_words.size() > 0) pkt_words[pkt_words.size()-1].is_last = 1'b1;
    foreach (pkt_words[i]) expected_words.push_back(pkt_words[i]);
  endfunction

  // Sends one packet; valid stays high unless an idle gap follows.
  task automatic send_packet(logic [2:0] kind, logic [31:0] seq, logic [15:0] src,
                             logic [15:0] tag);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_seq <= seq;
    in_source <= src;
    in_payload_tag <= tag;
    do @(posedge clk); while (!in_ready);
    predict_packet(kind, seq, src, tag);
    if (kind < K_ACK) items_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes both registers once the receiver has gone quiet.
  task automatic set_config(logic sel, logic [5:0] wsize);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SEL_REPEAT;
    cfg_data <= {5'd0, sel};
    do @(posedge clk); while (!cfg_ready);
    m_sel_repeat = sel;
    cfg_index <= CFG_WINDOW_SIZE;
    cfg_data <= wsize;
    do @(posedge clk); while (!cfg_ready);
    m_win_size = wsize;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_seq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom;
    if (r < 25) return m_low - 32'($urandom_range(1, 8));
    return m_low + 32'($urandom_range(0, eff_window() + 2));
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    word_t exp_w;
    word_t got_w;
    if (rst_n && out_valid && out_ready) begin
      got_w = '{out_result_kind, out_result_seq, out_acked_kind, out_destination,
                out_delivered_tag, out_last};
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got_w);
      end else begin
        exp_w = expected_words.pop_front();
        if (got_w !== exp_w) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_w, got_w);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sliding_window_receiver_unit_tb failed");
      $finish;
    end
  end

  task automatic test_idle_packets();
    send_packet(K_DATA, 32'd100, 16'd1, 16'h1111);   // outside window at idle: dropped
    send_packet(K_DATA, 32'd0, 16'd1, 16'hFFFF);     // inside window, peer still unknown
    send_packet(K_ACK, 32'd1, 16'd2, 16'd3);
    send_packet(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_go_back_n_session();
    send_packet(K_CONN, 32'd40, 16'hFFFF, 16'h0000);
    send_packet(K_PUSH, 32'd42, 16'h0, 16'hA5A5);
    send_packet(K_DATA, 32'd41, 16'h0, 16'h5A5A);
    send_packet(K_DATA, 32'd41, 16'h0, 16'h1234);
    send_packet(K_DATA, 32'd100, 16'h0, 16'h4321);
    send_packet(K_STOP, 32'd43, 16'h0, 16'h0F0F);
    send_packet(K_DISCONNECT, 32'd44, 16'h0, 16'hF0F0);
  endtask

  task automatic test_selective_session();
    set_config(1'b1, 6'd8);
    send_packet(K_CONN, 32'd5, 16'h0000, 16'h0001);
    send_packet(K_DATA, 32'd50, 16'h0, 16'h0002);
    send_packet(K_DATA, 32'd3, 16'h0, 16'h0003);
    send_packet(K_STOP, 32'd6, 16'h0, 16'h0004);     // wrong kind while connected
    send_packet(K_DATA, 32'd8, 16'h0, 16'hAAAA);
    send_packet(K_DATA, 32'd8, 16'h0, 16'h5555);     // the first tag in a slot wins
    send_packet(K_DATA, 32'd7, 16'h0, 16'h0005);
    send_packet(K_DISCONNECT, 32'd9, 16'h0, 16'h0006);
  endtask

  task automatic test_window_edges();
    set_config(1'b0, 6'd63);
    send_packet(K_CONN, 32'hFFFF_FFFC, 16'h1234, 16'h0);
    send_packet(K_DATA, 32'hFFFF_FFFE, 16'h0, 16'h0011);
    send_packet(K_DATA, 32'hFFFF_FFFF, 16'h0, 16'h0022);
    send_packet(K_DATA, 32'hFFFF_FFFD, 16'h0, 16'h0033);
    send_packet(K_DATA, 32'd0, 16'h0, 16'h0044);
    send_packet(K_DISCONNECT, 32'd1, 16'h0, 16'h0055);
    set_config(1'b0, 6'd0);
    send_packet(K_CONN, 32'h8000_0000, 16'h8001, 16'h0);
    send_packet(K_DATA, 32'h8000_0002, 16'h0, 16'h0066);
    send_packet(K_DISCONNECT, 32'h8000_0001, 16'h0, 16'h0077);
  endtask

  // Well-formed sessions with shuffled data, followed by a few stray packets.
  task automatic test_random_sessions(int goal);
    logic [31:0] base;
    int n;
    int tmp;
    int j;
    int order[$];
    logic [2:0] kind;
    while (items_sent < goal) begin
      base = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 40))
                                          : $urandom;
      send_packet(K_CONN, base, 16'($urandom), 16'($urandom));
      n = $urandom_range(1, ((eff_window() < 6) ? eff_window() : 6) + 2);
      order.delete();
      for (int i = 1; i <= n; i++) order.push_back(i);
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      foreach (order[i]) begin
        kind = (i == 0) ? K_PUSH : ((i == n - 1) ? K_STOP : K_DATA);
        send_packet(kind, base + 32'(order[i]), 16'($urandom), 16'($urandom));
      end
      send_packet(K_DISCONNECT, m_low, 16'($urandom), 16'($urandom));
      repeat ($urandom_range(0, 3))
        send_packet(3'($urandom_range(0, 7)), pick_seq(), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic       sel_list [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [5:0] size_list [6] = '{6'd8, 6'd1, 6'd32, 6'd0, 6'd63, 6'd5};
    reset_receiver();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_packets();
    test_go_back_n_session();
    test_selective_session();
    test_window_edges();
    for (int p = 0; p < 6; p++) begin
      set_config(sel_list[p], size_list[p]);
      if (p == 5) quiet = 1;
      test_random_sessions(items_sent + RAND_ITEMS / 6);
    end
    wait_drained();
    $display("Covered %0d packets and %0d result words over six window settings,",
             items_sent, words_checked);
    $display("with %0d mismatching words.", mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("sliding_window_receiver_unit_tb passed");
    end else begin
      $display("sliding_window_receiver_unit_tb failed");
    end
    $finish;
  end
endmodule
